// ----- rtl/core/mandelbrot_escape_pixel_unit_macros.svh -----
// Assertion macros shared by the Mandelbrot escape-time pixel unit.
`ifndef MANDELBROT_ESCAPE_PIXEL_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_PIXEL_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MEP_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mep assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MEP_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mep assertion failed");

`endif

// ----- rtl/core/mep_pkg.sv -----
// Types and constants of the Mandelbrot escape-time pixel unit.
package mep_pkg;

  // Fixed-point format and image limits
  localparam int FRAC_BITS = 28;
  localparam int MAX_DIM   = 4096;
  localparam int COORD_W   = 32;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_REAL_MIN = 3'd0;
  localparam logic [2:0] REG_REAL_MAX = 3'd1;
  localparam logic [2:0] REG_IMAG_MIN = 3'd2;
  localparam logic [2:0] REG_IMAG_MAX = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;
  localparam logic [2:0] REG_MAX_ITER = 3'd6;

  // 255^8, the full-scale term of the colour rule
  localparam logic [63:0] FULL_SCALE_8 = 64'd17878103347812890625;

  // x/5 as (x*205)>>10, exact for x up to 765
  localparam logic [17:0] RECIP_5     = 18'd205;
  localparam int          RECIP_SHIFT = 10;

  // Mapped point handed from the front end to the iteration engine
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } coord_t;

endpackage

// ----- rtl/core/mep_pixel_if.sv -----
// Pixel request channel: row and column of one pixel.
interface mep_pixel_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_row;
  logic [11:0] pixel_col;

  modport source (output valid, pixel_row, pixel_col, input ready);
  modport sink (input valid, pixel_row, pixel_col, output ready);
endinterface

// ----- rtl/core/mep_result_if.sv -----
// Result channel: escape count and pixel colour.
interface mep_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] escape_count;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (output valid, escape_count, red, green, blue, input ready);
  modport sink (input valid, escape_count, red, green, blue, output ready);
endinterface

// ----- rtl/core/mep_front.sv -----
// Front end: accepts pixel requests and maps them onto the complex plane.
module mep_front import mep_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  mep_pixel_if.sink                 pixel,
  input  logic signed [COORD_W-1:0] real_min,
  input  logic signed [COORD_W-1:0] real_max,
  input  logic signed [COORD_W-1:0] imag_min,
  input  logic signed [COORD_W-1:0] imag_max,
  input  logic [12:0]               image_width,
  input  logic [12:0]               image_height,
  output logic                      pt_valid,
  input  logic                      pt_ready,
  output coord_t                    pt_data
);

  localparam int NUM_W = 47;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULA = 3'd1;
  localparam logic [2:0] ST_MULB = 3'd2;
  localparam logic [2:0] ST_ABS  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_SAT  = 3'd5;
  localparam logic [2:0] ST_PUSH = 3'd6;

  localparam logic [NUM_W-1:0] POS_LIMIT = NUM_W'(64'h7FFF_FFFF);
  localparam logic [NUM_W-1:0] NEG_LIMIT = NUM_W'(64'h8000_0000);

  logic [2:0]                state;
  logic                      axis;
  logic [11:0]               row;
  logic [11:0]               col;
  logic signed [NUM_W-1:0]   acc;
  logic [NUM_W-1:0]          mag;
  logic                      neg;
  logic [11:0]               rem;
  logic [CNT_W-1:0]          cnt;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;

  logic [11:0]               idx;
  logic signed [COORD_W-1:0] lo;
  logic signed [COORD_W-1:0] hi;
  logic [12:0]               dim;
  logic [12:0]               dclamp;
  logic [12:0]               dm1;
  logic signed [13:0]        span;
  logic signed [44:0]        prod_a;
  logic signed [45:0]        prod_b;
  logic [12:0]               trial;
  logic signed [COORD_W-1:0] sat;

  // Select the axis in work: rows map onto imaginary, columns onto real
  always_comb begin
    idx    = axis ? col : row;
    lo     = axis ? real_min : imag_min;
    hi     = axis ? real_max : imag_max;
    dim    = axis ? image_width : image_height;
    dclamp = dim;
    if (dim < 13'd2) begin
      dclamp = 13'd2;
    end else if (32'(dim) > 32'(MAX_DIM)) begin
      dclamp = 13'(MAX_DIM);
    end
    dm1    = dclamp - 13'd1;
    span   = $signed({1'b0, dm1}) - $signed({2'b0, idx});
    prod_a = 45'($signed({1'b0, idx}) * hi);
    prod_b = 46'(span * lo);
    trial  = {rem, mag[NUM_W-1]};
    if (neg) begin
      sat = (mag > NEG_LIMIT) ? $signed(NEG_LIMIT[COORD_W-1:0])
                              : $signed(COORD_W'(-mag));
    end else begin
      sat = (mag > POS_LIMIT) ? $signed(POS_LIMIT[COORD_W-1:0])
                              : $signed(mag[COORD_W-1:0]);
    end
  end

  assign pixel.ready = (state == ST_IDLE);
  assign pt_valid    = (state == ST_PUSH);
  assign pt_data     = '{cx: cx, cy: cy};

  // Sequence: two products, magnitude, bit-serial divide, saturate, per axis
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pixel.valid) begin
            row   <= pixel.pixel_row;
            col   <= pixel.pixel_col;
            axis  <= 1'b0;
            state <= ST_MULA;
          end
        end
        ST_MULA: begin
          acc   <= NUM_W'(prod_a);
          state <= ST_MULB;
        end
        ST_MULB: begin
          acc   <= acc + NUM_W'(prod_b);
          state <= ST_ABS;
        end
        ST_ABS: begin
          neg   <= acc[NUM_W-1];
          mag   <= acc[NUM_W-1] ? NUM_W'(-acc) : NUM_W'(acc);
          rem   <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (trial >= dm1) begin
            rem <= 12'(trial - dm1);
            mag <= {mag[NUM_W-2:0], 1'b1};
          end else begin
            rem <= trial[11:0];
            mag <= {mag[NUM_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_W - 1)) begin
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (axis) begin
            cx    <= sat;
            state <= ST_PUSH;
          end else begin
            cy    <= sat;
            axis  <= 1'b1;
            state <= ST_MULA;
          end
        end
        ST_PUSH: begin
          if (pt_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/mep_queue.sv -----
// Two-entry queue of mapped points between front end and iteration engine.
module mep_queue import mep_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t out_data
);

  coord_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Store incoming points
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/mep_iter.sv -----
// Iteration engine: runs z = z*z + c, one step per cycle, until escape or the step limit max_iter.
module mep_iter import mep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pt_valid,
  output logic        pt_ready,
  input  coord_t      pt_data,
  input  logic [15:0] max_iter,
  output logic        cnt_valid,
  input  logic        cnt_ready,
  output logic [15:0] count
);

  localparam int NEXT_W = 38;
  localparam logic signed [NEXT_W-1:0] BOUND = NEXT_W'(64'sd1 <<< (FRAC_BITS + 1));

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                state;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic [15:0]               k;

  logic signed [63:0]        xx;
  logic signed [63:0]        yy;
  logic signed [63:0]        xy;
  logic signed [NEXT_W-1:0]  nx;
  logic signed [NEXT_W-1:0]  ny;
  logic                      esc;

  // One step: exact products, floor shifts, escape test against +-2
  always_comb begin
    xx  = 64'(x * x);
    yy  = 64'(y * y);
    xy  = 64'(x * y);
    nx  = NEXT_W'(xx >>> FRAC_BITS) - NEXT_W'(yy >>> FRAC_BITS) + NEXT_W'(cx);
    ny  = NEXT_W'(xy >>> (FRAC_BITS - 1)) + NEXT_W'(cy);
    esc = (nx < -BOUND) || (nx > BOUND) || (ny < -BOUND) || (ny > BOUND);
  end

  assign pt_ready  = (state == ST_IDLE);
  assign cnt_valid = (state == ST_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pt_valid) begin
            cx <= pt_data.cx;
            cy <= pt_data.cy;
            x  <= pt_data.cx;
            y  <= pt_data.cy;
            k  <= 16'd1;
            if (max_iter == 16'd0) begin
              count <= 16'd0;
              state <= ST_HOLD;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (esc) begin
            count <= k;
            state <= ST_HOLD;
          end else if (k == max_iter) begin
            count <= 16'd0;
            state <= ST_HOLD;
          end else begin
            x <= COORD_W'(nx);
            y <= COORD_W'(ny);
            k <= k + 16'd1;
          end
        end
        ST_HOLD: begin
          if (cnt_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/mep_colour.sv -----
// Colour stage: turns an escape count into RGB and holds the result.
module mep_colour import mep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cnt_valid,
  output logic        cnt_ready,
  input  logic [15:0] count,
  input  logic [15:0] max_iter,
  mep_result_if.source result
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RHS  = 3'd1;
  localparam logic [2:0] ST_SQ2  = 3'd2;
  localparam logic [2:0] ST_SQ4  = 3'd3;
  localparam logic [2:0] ST_SQ8  = 3'd4;
  localparam logic [2:0] ST_LHS  = 3'd5;
  localparam logic [2:0] ST_CMP  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]  state;
  logic [15:0] cnt;
  logic [79:0] rhs;
  logic [79:0] lhs;
  logic [15:0] sq2;
  logic [31:0] sq4;
  logic [63:0] sq8;
  logic [7:0]  level;
  logic [2:0]  bitpos;
  logic [7:0]  red;
  logic [7:0]  blue;

  logic [7:0]  trial;
  logic [7:0]  level_next;
  logic [9:0]  triple;
  logic [17:0] scaled;

  // Trial level of the bit search and the 3/5 scaling of the final level
  always_comb begin
    trial      = level | (8'd1 << bitpos);
    level_next = (lhs <= rhs) ? trial : level;
    triple     = 10'({level_next, 1'b0}) + 10'(level_next);
    scaled     = 18'(triple) * RECIP_5;
  end

  assign cnt_ready           = (state == ST_IDLE);
  assign result.valid        = (state == ST_DONE);
  assign result.escape_count = cnt;
  assign result.red          = red;
  assign result.green        = red;
  assign result.blue         = blue;

  // Odd counts give white; for even ones search the largest level with level^8 * max_iter <= count * 255^8
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cnt_valid) begin
            cnt <= count;
            if (count[0]) begin
              red   <= 8'd255;
              blue  <= 8'd255;
              state <= ST_DONE;
            end else begin
              state <= ST_RHS;
            end
          end
        end
        ST_RHS: begin
          rhs    <= 80'(cnt) * 80'(FULL_SCALE_8);
          level  <= 8'd0;
          bitpos <= 3'd7;
          state  <= ST_SQ2;
        end
        ST_SQ2: begin
          sq2   <= 16'(trial) * 16'(trial);
          state <= ST_SQ4;
        end
        ST_SQ4: begin
          sq4   <= 32'(sq2) * 32'(sq2);
          state <= ST_SQ8;
        end
        ST_SQ8: begin
          sq8   <= 64'(sq4) * 64'(sq4);
          state <= ST_LHS;
        end
        ST_LHS: begin
          lhs   <= 80'(sq8) * 80'(max_iter);
          state <= ST_CMP;
        end
        ST_CMP: begin
          level <= level_next;
          if (bitpos == 3'd0) begin
            red   <= scaled[RECIP_SHIFT +: 8];
            blue  <= level_next;
            state <= ST_DONE;
          end else begin
            bitpos <= bitpos - 3'd1;
            state  <= ST_SQ2;
          end
        end
        ST_DONE: begin
          if (result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/mandelbrot_escape_pixel_unit.sv -----
// Mandelbrot escape-time pixel unit: top level with configuration registers.
//
// Requests arrive on the pixel channel (valid/ready, row and column); each one
// returns one response on the result channel: escape count and RGB colour.
// The front end maps a pixel onto the plane box with two bit-serial 47-step
// divides, one per axis, then parks the point in a two-entry queue.
// The iteration engine runs one z*z + c step per cycle, for up to max_iter
// steps per pixel; this loop sets throughput.
// The colour stage runs an eight-bit search for even counts (per bit: square,
// fourth power, eighth power, product with max_iter, compare) and passes odd
// ones straight to its output, overlapping the next iteration.
// When the receiver stalls, the result holds in the colour stage's output
// registers, the engine finishes its pixel and waits, and the queue and front
// end fill; pixel.ready stays low while the front end holds a request.
// Reset (rst, synchronous) empties all stages and loads the default box (-2.25..1.25,
// -1.75..1.75), 500 x 500 pixels and max_iter 2000. The user must write registers over
// the APB port only while no request is in flight; the block does not enforce it.
module mandelbrot_escape_pixel_unit import mep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mep_pixel_if.sink   pixel,
  mep_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "mandelbrot_escape_pixel_unit_macros.svh"

  logic signed [COORD_W-1:0] real_min;
  logic signed [COORD_W-1:0] real_max;
  logic signed [COORD_W-1:0] imag_min;
  logic signed [COORD_W-1:0] imag_max;
  logic [12:0]               image_width;
  logic [12:0]               image_height;
  logic [15:0]               max_iter;

  logic        wr_en;
  logic [2:0]  reg_idx;
  logic        fq_valid;
  logic        fq_ready;
  coord_t      fq_data;
  logic        qi_valid;
  logic        qi_ready;
  coord_t      qi_data;
  logic        ic_valid;
  logic        ic_ready;
  logic [15:0] ic_count;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      real_min     <= -32'sd603979776;
      real_max     <= 32'sd335544320;
      imag_min     <= -32'sd469762048;
      imag_max     <= 32'sd469762048;
      image_width  <= 13'd500;
      image_height <= 13'd500;
      max_iter     <= 16'd2000;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_REAL_MIN: real_min     <= $signed(pwdata);
        REG_REAL_MAX: real_max     <= $signed(pwdata);
        REG_IMAG_MIN: imag_min     <= $signed(pwdata);
        REG_IMAG_MAX: imag_max     <= $signed(pwdata);
        REG_WIDTH:    image_width  <= pwdata[12:0];
        REG_HEIGHT:   image_height <= pwdata[12:0];
        REG_MAX_ITER: max_iter     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_idx)
      REG_REAL_MIN: prdata = real_min;
      REG_REAL_MAX: prdata = real_max;
      REG_IMAG_MIN: prdata = imag_min;
      REG_IMAG_MAX: prdata = imag_max;
      REG_WIDTH:    prdata = 32'(image_width);
      REG_HEIGHT:   prdata = 32'(image_height);
      REG_MAX_ITER: prdata = 32'(max_iter);
      default:      prdata = 32'd0;
    endcase
  end

  mep_front u_front (
    .clk          (clk),
    .rst          (rst),
    .pixel        (pixel),
    .real_min     (real_min),
    .real_max     (real_max),
    .imag_min     (imag_min),
    .imag_max     (imag_max),
    .image_width  (image_width),
    .image_height (image_height),
    .pt_valid     (fq_valid),
    .pt_ready     (fq_ready),
    .pt_data      (fq_data)
  );

  mep_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qi_valid),
    .out_ready (qi_ready),
    .out_data  (qi_data)
  );

  mep_iter u_iter (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (qi_valid),
    .pt_ready  (qi_ready),
    .pt_data   (qi_data),
    .max_iter  (max_iter),
    .cnt_valid (ic_valid),
    .cnt_ready (ic_ready),
    .count     (ic_count)
  );

  mep_colour u_colour (
    .clk       (clk),
    .rst       (rst),
    .cnt_valid (ic_valid),
    .cnt_ready (ic_ready),
    .count     (ic_count),
    .max_iter  (max_iter),
    .result    (result)
  );

  // Odd counts are white, red tracks green, counts stay in range, stalled results hold
  `MEP_ASSERT_IMP(a_odd_white, result.valid && result.escape_count[0], result.red == 8'd255 && result.blue == 8'd255)
  `MEP_ASSERT_IMP(a_red_green, result.valid, result.red == result.green)
  `MEP_ASSERT_IMP(a_count_range, ic_valid, ic_count <= max_iter)
  `MEP_ASSERT_NXT(a_hold_result, result.valid && !result.ready, result.valid && $stable(result.escape_count))

endmodule

// ----- tb/mandelbrot_escape_pixel_unit_tb.sv -----
// Self-checking testbench for the Mandelbrot escape-time pixel unit.
`timescale 1ns / 100ps

module mandelbrot_escape_pixel_unit_tb;
  import mep_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct {
    logic [11:0] row;
    logic [11:0] col;
  } pixel_req_t;

  typedef struct {
    logic [15:0] count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_colour_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mep_pixel_if  pixel_ch ();
  mep_result_if result_ch ();

  mandelbrot_escape_pixel_unit uut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the configuration registers
  longint      box_re_lo, box_re_hi, box_im_lo, box_im_hi;
  logic [12:0] img_cols, img_rows;
  logic [15:0] iter_limit;

  pixel_req_t    pending_pixels[$];
  pixel_colour_t expected_colours[$];

  int  error_count;
  int  requests_sent;
  int  colours_seen;
  int  phase_count;
  int  stall_cycles;
  bit  quiet_run;

  always #10 clk = ~clk;

  // floor(a*b / 2^s) with an exact 128-bit product
  function automatic longint floor_mul(longint a, longint b, int s);
    logic signed [127:0] wa, wb, prod;
    wa = a;
    wb = b;
    prod = (wa * wb) >>> s;
    return longint'(prod[63:0]);
  endfunction

  // Map a pixel index linearly onto one axis of the plane box
  function automatic longint axis_point(logic [11:0] idx, logic [12:0] dim,
                                        longint lo, longint hi);
    longint d, i, v;
    d = (dim < 2) ? 2 : ((dim > MAX_DIM) ? MAX_DIM : dim);
    i = idx;
    v = (i * hi + (d - 1 - i) * lo) / (d - 1);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  // Largest v with v^8 * iters <= count * 255^8
  function automatic logic [7:0] shade_level(longint unsigned count,
                                             longint unsigned iters);
    logic [127:0]    lhs, rhs;
    longint unsigned p8;
    int              k, e;
    p8 = 1;
    for (e = 0; e < 8; e++) p8 = p8 * 255;
    rhs = 128'(count) * 128'(p8);
    for (k = 255; k > 0; k--) begin
      p8 = 1;
      for (e = 0; e < 8; e++) p8 = p8 * longint'(k);
      lhs = 128'(p8) * 128'(iters);
      if (lhs <= rhs) return k[7:0];
    end
    return 8'd0;
  endfunction

  // Escape count and colour of one pixel under the current configuration
  function automatic pixel_colour_t predict_colour(logic [11:0] row, logic [11:0] col);
    pixel_colour_t res;
    longint        cx, cy, x, y, nx, ny, bound;
    int            k;
    logic [7:0]    v;
    cy = axis_point(row, img_rows, box_im_lo, box_im_hi);
    cx = axis_point(col, img_cols, box_re_lo, box_re_hi);
    bound = 64'sd1 <<< (FRAC_BITS + 1);
    x = cx;
    y = cy;
    res.count = 16'd0;
    for (k = 1; k <= int'(iter_limit); k++) begin
      nx = floor_mul(x, x, FRAC_BITS) - floor_mul(y, y, FRAC_BITS) + cx;
      ny = floor_mul(x, y, FRAC_BITS - 1) + cy;
      if (nx < -bound || nx > bound || ny < -bound || ny > bound) begin
        res.count = k[15:0];
        break;
      end
      x = nx;
      y = ny;
    end
    if (res.count[0]) begin
      res.red = 8'd255;
      res.green = 8'd255;
      res.blue = 8'd255;
    end else begin
      v = shade_level(res.count, iter_limit);
      res.red = 8'((3 * int'(v)) / 5);
      res.green = res.red;
      res.blue = v;
    end
    return res;
  endfunction

  // Pixel driver: predict on each accepted request, then load the next one
  always @(posedge clk) begin
    if (rst) begin
      pixel_ch.valid <= 1'b0;
    end else begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        expected_colours.push_back(predict_colour(pixel_ch.pixel_row, pixel_ch.pixel_col));
        requests_sent++;
      end
      if (!pixel_ch.valid || pixel_ch.ready) begin
        if (pending_pixels.size() > 0 && (quiet_run || $urandom_range(0, 99) >= 9)) begin
          pixel_ch.valid <= 1'b1;
          pixel_ch.pixel_row <= pending_pixels[0].row;
          pixel_ch.pixel_col <= pending_pixels[0].col;
          void'(pending_pixels.pop_front());
        end else begin
          pixel_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure, compare against the oldest prediction
  always @(posedge clk) begin
    pixel_colour_t exp_c;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        colours_seen++;
        if (expected_colours.size() == 0) begin
          $error("result with no request outstanding: count %0d", result_ch.escape_count);
          error_count++;
        end else begin
          exp_c = expected_colours.pop_front();
          if (result_ch.escape_count !== exp_c.count) begin
            $error("escape_count expected %0d got %0d", exp_c.count, result_ch.escape_count);
            error_count++;
          end
          if (result_ch.red !== exp_c.red) begin
            $error("red expected %0d got %0d", exp_c.red, result_ch.red);
            error_count++;
          end
          if (result_ch.green !== exp_c.green) begin
            $error("green expected %0d got %0d", exp_c.green, result_ch.green);
            error_count++;
          end
          if (result_ch.blue !== exp_c.blue) begin
            $error("blue expected %0d got %0d", exp_c.blue, result_ch.blue);
            error_count++;
          end
        end
      end
      result_ch.ready <= quiet_run || ($urandom_range(0, 99) >= 9);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)
        || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Write one register over APB and track it in the shadow copy
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_REAL_MIN: box_re_lo = longint'(signed'(val));
      REG_REAL_MAX: box_re_hi = longint'(signed'(val));
      REG_IMAG_MIN: box_im_lo = longint'(signed'(val));
      REG_IMAG_MAX: box_im_hi = longint'(signed'(val));
      REG_WIDTH:    img_cols = val[12:0];
      REG_HEIGHT:   img_rows = val[12:0];
      REG_MAX_ITER: iter_limit = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_box(logic [31:0] re_lo, logic [31:0] re_hi, logic [31:0] im_lo,
                          logic [31:0] im_hi, logic [31:0] cols, logic [31:0] rows,
                          logic [31:0] iters);
    reg_write(REG_REAL_MIN, re_lo);
    reg_write(REG_REAL_MAX, re_hi);
    reg_write(REG_IMAG_MIN, im_lo);
    reg_write(REG_IMAG_MAX, im_hi);
    reg_write(REG_WIDTH, cols);
    reg_write(REG_HEIGHT, rows);
    reg_write(REG_MAX_ITER, iters);
  endtask

  task automatic queue_pixel(int row, int col);
    pixel_req_t req;
    req.row = row[11:0];
    req.col = col[11:0];
    pending_pixels.push_back(req);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_all();
    do @(posedge clk);
    while (pending_pixels.size() > 0 || pixel_ch.valid || expected_colours.size() > 0);
    repeat (10) @(posedge clk);
    phase_count++;
  endtask

  // One random configuration followed by a batch of random pixels
  task automatic random_phase(int n);
    int          i, cols, rows;
    logic [31:0] re_lo, re_hi, im_lo, im_hi;
    if ($urandom_range(0, 3) == 0) begin
      re_lo = $urandom;
      re_hi = $urandom;
      im_lo = $urandom;
      im_hi = $urandom;
    end else begin
      re_lo = -32'($urandom_range(0, 671088640));
      re_hi = 32'($urandom_range(0, 536870912));
      im_lo = -32'($urandom_range(0, 536870912));
      im_hi = 32'($urandom_range(0, 536870912));
    end
    cols = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) : $urandom_range(2, 600);
    rows = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) : $urandom_range(2, 600);
    load_box(re_lo, re_hi, im_lo, im_hi, cols, rows, $urandom_range(1, 300));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      else
        queue_pixel($urandom_range(0, (rows > 4096 ? 4096 : (rows < 2 ? 2 : rows)) - 1),
                    $urandom_range(0, (cols > 4096 ? 4096 : (cols < 2 ? 2 : cols)) - 1));
    end
    drain_all();
  endtask

  initial begin
    int p;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.pixel_row = '0;
    pixel_ch.pixel_col = '0;
    result_ch.ready = 1'b0;
    error_count = 0;
    requests_sent = 0;
    colours_seen = 0;
    phase_count = 0;
    quiet_run = 1'b0;
    box_re_lo = -603979776;
    box_re_hi = 335544320;
    box_im_lo = -469762048;
    box_im_hi = 469762048;
    img_cols = 13'd500;
    img_rows = 13'd500;
    iter_limit = 16'd2000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset box: corners, a point inside the set, pixels beyond the image
    queue_pixel(0, 0);
    queue_pixel(499, 499);
    queue_pixel(250, 321);
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);
    queue_pixel(4095, 4095);
    queue_pixel(2048, 2730);
    queue_pixel(120, 380);
    drain_all();

    // Widest box, smallest and clamped dimensions, largest step limit
    load_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 8191, 65535);
    queue_pixel(0, 0);
    queue_pixel(0, 1);
    queue_pixel(1, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(2730, 1365);
    drain_all();

    // Degenerate box at the origin: runs the full step limit, count zero
    load_box(0, 0, 0, 0, 4096, 2, 65535);
    reg_write(3'd7, 32'hdead_beef);
    queue_pixel(1, 2);
    drain_all();

    // Zero step limit: count zero with the full-scale shade
    load_box(-603979776, 335544320, -469762048, 469762048, 1, 4097, 0);
    queue_pixel(3, 5);
    queue_pixel(4095, 4095);
    queue_pixel(1365, 2730);
    drain_all();

    // Random configurations; one of them runs with no idling on either side
    for (p = 0; p < 5; p++) begin
      quiet_run = (p == 2);
      random_phase(55);
    end
    quiet_run = 1'b0;

    $display("Sent %0d pixel requests over %0d configuration phases, checked %0d results.",
             requests_sent, phase_count, colours_seen);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
